// File: sv/drtm_pkg.sv
// Shared widths, register indexes and reset values of the drive request timing model.
package drtm_pkg;

  localparam int unsigned FileW   = 32;
  localparam int unsigned OffsetW = 40;
  localparam int unsigned CountW  = 32;
  localparam int unsigned MsW     = 48;
  localparam int unsigned FracW   = 16;
  localparam int unsigned TimeW   = MsW + FracW;
  localparam int unsigned NextW   = OffsetW + 1;
  localparam int unsigned CostW   = CountW + FracW + 1;

  localparam int unsigned SeekW   = 24;
  localparam int unsigned RateW   = 20;
  localparam int unsigned AheadW  = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned DividendW = CountW + FracW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODEL_ENABLE  = 3'd0,
    CFG_TIMING_SWITCH = 3'd1,
    CFG_SEEK_COST     = 3'd2,
    CFG_BYTES_PER_MS  = 3'd3,
    CFG_MAX_AHEAD     = 3'd4
  } cfg_idx_e;

  localparam logic              ModelEnableRst  = 1'b0;
  localparam logic              TimingSwitchRst = 1'b1;
  localparam logic [SeekW-1:0]  SeekCostRst     = 24'd393216;
  localparam logic [RateW-1:0]  BytesPerMsRst   = 20'd35000;
  localparam logic [AheadW-1:0] MaxAheadRst     = 16'd4000;

endpackage

// File: sv/drtm_ifs.sv
// Valid/ready channel interfaces: request, response and configuration write.
interface drtm_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [drtm_pkg::FileW-1:0]           file_id;
  logic [drtm_pkg::OffsetW-1:0]         byte_offset;
  logic [drtm_pkg::CountW-1:0]          byte_count;
  logic [drtm_pkg::MsW-1:0]             now_ms;

  modport source (output valid, file_id, byte_offset, byte_count, now_ms, input ready);
  modport sink   (input valid, file_id, byte_offset, byte_count, now_ms, output ready);
endinterface

interface drtm_resp_if;
  logic                                 valid;
  logic                                 ready;
  logic [drtm_pkg::MsW-1:0]             ready_ms;

  modport source (output valid, ready_ms, input ready);
  modport sink   (input valid, ready_ms, output ready);
endinterface

interface drtm_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [drtm_pkg::CfgIdxW-1:0]         index;
  logic [drtm_pkg::CfgDataW-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/drtm_div.sv
// Restoring radix-2 divider: one quotient bit per cycle.
module drtm_div #(
  parameter int unsigned DividendW = drtm_pkg::DividendW,
  parameter int unsigned DivisorW  = drtm_pkg::RateW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW-1:0]  div_q;
  logic [DividendW-1:0] quo_q;

  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;
  logic                 ge;

  // quo_q shifts the dividend out at the top and the quotient in at the bottom
  assign trial = {rem_q, quo_q[DividendW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DividendW);
        rem_q  <= '0;
        div_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
        quo_q <= {quo_q[DividendW-2:0], ge};
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: sv/drive_request_timing_model.sv
// Top level of the drive request timing model.
//
// Usage: one request word on req (file_id, byte_offset, byte_count, now_ms) gives
// exactly one response word on resp (ready_ms, the completion time in whole ms).
// Registers are written on cfg (index, data) only while the block is idle: a rule
// for the user, which the block itself leaves unchecked; cfg is always ready.
// Indexes: 0 model_enable, 1 timing_switch, 2 seek_cost_q16, 3 bytes_per_ms,
// 4 max_ahead_ms; other indexes are ignored. With timing enabled an accepted
// request runs the bit-serial divide of byte_count * 65536 by the rate, then one
// registered step each for the cost add, backlog cap, max, clamp and saturating
// add, before the response word shows on resp. With timing disabled the response
// (0) shows in the cycle after accept and no state moves.
// Throughput: one request at a time; req.ready is high only when idle, so a
// new request can be taken the cycle after the previous response is taken.
// Reset (rst_ni low, asynchronous) clears the drive state (last file, next
// offset, free time) and loads the register defaults. If resp.ready stays low
// the response word holds and no new request is accepted.
module drive_request_timing_model (
  input  logic              clk_i,
  input  logic              rst_ni,
  drtm_req_if.sink          req,
  drtm_resp_if.source       resp,
  drtm_cfg_if.sink          cfg
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CAP,
    ST_MAX,
    ST_MIN,
    ST_ADD,
    ST_OUT
  } state_e;

  // configuration registers
  logic                            model_enable_q;
  logic                            timing_switch_q;
  logic [drtm_pkg::SeekW-1:0]      seek_cost_q;
  logic [drtm_pkg::RateW-1:0]      bytes_per_ms_q;
  logic [drtm_pkg::AheadW-1:0]     max_ahead_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_enable_q  <= drtm_pkg::ModelEnableRst;
      timing_switch_q <= drtm_pkg::TimingSwitchRst;
      seek_cost_q     <= drtm_pkg::SeekCostRst;
      bytes_per_ms_q  <= drtm_pkg::BytesPerMsRst;
      max_ahead_q     <= drtm_pkg::MaxAheadRst;
    end else if (cfg.valid) begin
      case (cfg.index)
        drtm_pkg::CFG_MODEL_ENABLE:  model_enable_q  <= cfg.data[0];
        drtm_pkg::CFG_TIMING_SWITCH: timing_switch_q <= cfg.data[0];
        drtm_pkg::CFG_SEEK_COST:     seek_cost_q     <= cfg.data[drtm_pkg::SeekW-1:0];
        drtm_pkg::CFG_BYTES_PER_MS:  bytes_per_ms_q  <= cfg.data[drtm_pkg::RateW-1:0];
        drtm_pkg::CFG_MAX_AHEAD:     max_ahead_q     <= cfg.data[drtm_pkg::AheadW-1:0];
        default: ;
      endcase
    end
  end

  state_e                          state_q;
  logic [drtm_pkg::FileW-1:0]      last_file_q;
  logic [drtm_pkg::NextW-1:0]      next_offset_q;
  logic [drtm_pkg::TimeW-1:0]      free_q;
  logic [drtm_pkg::MsW-1:0]        now_q;
  logic                            seek_q;
  logic [drtm_pkg::CostW-1:0]      cost_q;
  logic [drtm_pkg::TimeW-1:0]      cap_q;
  logic [drtm_pkg::TimeW-1:0]      start_q;
  logic [drtm_pkg::MsW-1:0]        ready_ms_q;

  logic                            accept;
  logic                            enabled;
  logic                            seek;
  logic [drtm_pkg::RateW-1:0]      divisor;
  logic                            div_done;
  logic [drtm_pkg::DividendW-1:0]  quotient;
  logic [drtm_pkg::MsW:0]          cap_ms;
  logic [drtm_pkg::TimeW-1:0]      now_fix;
  logic [drtm_pkg::TimeW:0]        free_sum;
  logic [drtm_pkg::TimeW-1:0]      free_new;

  assign accept  = req.valid && req.ready;
  assign enabled = model_enable_q && timing_switch_q;
  assign seek    = (req.file_id != last_file_q) ||
                   ({1'b0, req.byte_offset} != next_offset_q);
  // a zero rate divides as one
  assign divisor = (bytes_per_ms_q == '0) ? drtm_pkg::RateW'(1) : bytes_per_ms_q;

  drtm_div #(
    .DividendW (drtm_pkg::DividendW),
    .DivisorW  (drtm_pkg::RateW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && enabled),
    .dividend_i ({req.byte_count, drtm_pkg::FracW'(0)}),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    cap_ms   = {1'b0, now_q} + (drtm_pkg::MsW + 1)'(max_ahead_q);
    now_fix  = {now_q, drtm_pkg::FracW'(0)};
    free_sum = {1'b0, start_q} + (drtm_pkg::TimeW + 1)'(cost_q);
    free_new = free_sum[drtm_pkg::TimeW] ? '1 : free_sum[drtm_pkg::TimeW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      last_file_q   <= '0;
      next_offset_q <= '0;
      free_q        <= '0;
      now_q         <= '0;
      seek_q        <= 1'b0;
      cost_q        <= '0;
      cap_q         <= '0;
      start_q       <= '0;
      ready_ms_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (enabled) begin
              seek_q        <= seek;
              now_q         <= req.now_ms;
              last_file_q   <= req.file_id;
              next_offset_q <= {1'b0, req.byte_offset} + drtm_pkg::NextW'(req.byte_count);
              state_q       <= ST_DIV;
            end else begin
              ready_ms_q <= '0;
              state_q    <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            cost_q  <= {1'b0, quotient} +
                       (seek_q ? drtm_pkg::CostW'(seek_cost_q) : '0);
            state_q <= ST_CAP;
          end
        end
        ST_CAP: begin
          // cap saturates once now + backlog no longer fits the integer part
          cap_q   <= cap_ms[drtm_pkg::MsW] ? '1
                     : {cap_ms[drtm_pkg::MsW-1:0], drtm_pkg::FracW'(0)};
          state_q <= ST_MAX;
        end
        ST_MAX: begin
          start_q <= (free_q > now_fix) ? free_q : now_fix;
          state_q <= ST_MIN;
        end
        ST_MIN: begin
          if (start_q > cap_q) begin
            start_q <= cap_q;
          end
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          free_q     <= free_new;
          ready_ms_q <= free_new[drtm_pkg::TimeW-1:drtm_pkg::FracW];
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (resp.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign req.ready     = (state_q == ST_IDLE);
  assign resp.valid    = (state_q == ST_OUT);
  assign resp.ready_ms = ready_ms_q;

endmodule

// File: verif/tb_drive_timing_checker.sv
// Checker for the drive request timing model: predicts each response word and compares.
module drive_timing_checker
  import drtm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  drtm_req_if   req,
  drtm_resp_if  resp,
  drtm_cfg_if   cfg,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic              cfg_enable;
  logic              cfg_switch;
  logic [SeekW-1:0]  cfg_seek;
  logic [RateW-1:0]  cfg_rate;
  logic [AheadW-1:0] cfg_ahead;

  // drive state
  logic [FileW-1:0]  prev_file;
  logic [NextW-1:0]  resume_offset;
  logic [TimeW-1:0]  free_at_q16;

  logic [MsW-1:0]    ready_ms_q[$];
  int                fails = 0;

  assign fail_count_o = fails;

  // If enabled, books one read and returns its completion time in whole ms; else 0.
  function automatic logic [MsW-1:0] book_drive_time(input logic [FileW-1:0]   fid,
                                                     input logic [OffsetW-1:0] off,
                                                     input logic [CountW-1:0]  cnt,
                                                     input logic [MsW-1:0]     now);
    logic [TimeW-1:0] xfer;
    logic [TimeW-1:0] now_q;
    logic [TimeW-1:0] cap;
    logic [TimeW-1:0] start;
    logic [TimeW:0]   sum;
    logic [RateW-1:0] rate;
    logic             continues;
    if (!cfg_enable || !cfg_switch) return '0;
    continues     = (fid == prev_file) && ({1'b0, off} == resume_offset);
    prev_file     = fid;
    resume_offset = {1'b0, off} + NextW'(cnt);
    rate  = (cfg_rate == '0) ? RateW'(1) : cfg_rate;
    xfer  = TimeW'({cnt, {FracW{1'b0}}}) / TimeW'(rate);
    if (!continues) xfer += TimeW'(cfg_seek);
    now_q = {now, {FracW{1'b0}}};
    sum   = {1'b0, now_q} + (TimeW+1)'({cfg_ahead, {FracW{1'b0}}});
    cap   = sum[TimeW] ? '1 : sum[TimeW-1:0];
    start = (free_at_q16 > now_q) ? free_at_q16 : now_q;
    if (start > cap) start = cap;    // reserved time past the backlog limit is dropped
    sum         = {1'b0, start} + (TimeW+1)'(xfer);
    free_at_q16 = sum[TimeW] ? '1 : sum[TimeW-1:0];
    return free_at_q16[TimeW-1:FracW];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [MsW-1:0] want;
    if (!rst_ni) begin
      cfg_enable    = ModelEnableRst;
      cfg_switch    = TimingSwitchRst;
      cfg_seek      = SeekCostRst;
      cfg_rate      = BytesPerMsRst;
      cfg_ahead     = MaxAheadRst;
      prev_file     = '0;
      resume_offset = '0;
      free_at_q16   = '0;
      ready_ms_q.delete();
      pending_o    <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_e'(cfg.index))
          CFG_MODEL_ENABLE:  cfg_enable = cfg.data[0];
          CFG_TIMING_SWITCH: cfg_switch = cfg.data[0];
          CFG_SEEK_COST:     cfg_seek   = cfg.data[SeekW-1:0];
          CFG_BYTES_PER_MS:  cfg_rate   = cfg.data[RateW-1:0];
          CFG_MAX_AHEAD:     cfg_ahead  = cfg.data[AheadW-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        ready_ms_q.push_back(book_drive_time(req.file_id, req.byte_offset,
                                             req.byte_count, req.now_ms));
      if (resp.valid && resp.ready) begin
        if (ready_ms_q.size() == 0) begin
          $display("%0t: ready_ms word with none expected: expected nothing, got %0d",
                   $time, resp.ready_ms);
          fails++;
        end else begin
          want = ready_ms_q.pop_front();
          if (resp.ready_ms !== want) begin
            $display("%0t: ready_ms mismatch: expected %0d, got %0d",
                     $time, want, resp.ready_ms);
            fails++;
          end
        end
      end
      pending_o <= ready_ms_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top: drives requests and register writes into the timing model and gives the verdict.
module tb_top;
  import drtm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 4000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;

  // stimulus trackers, used to build reads that continue the previous one
  logic [FileW-1:0] cur_file = '0;
  logic [NextW-1:0] cur_next = '0;
  logic [MsW-1:0]   clock_ms = '0;

  drtm_req_if  req_ch ();
  drtm_resp_if resp_ch ();
  drtm_cfg_if  cfg_ch ();

  drive_request_timing_model DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_ch),
    .resp   (resp_ch),
    .cfg    (cfg_ch)
  );

  drive_timing_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req          (req_ch),
    .resp         (resp_ch),
    .cfg          (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    resp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && !(req_ch.valid && req_ch.ready) && !(resp_ch.valid && resp_ch.ready)
        && !(cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, StallLimit);
        $display("TB_ERROR");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  task automatic send_read(input logic [FileW-1:0] fid, input logic [OffsetW-1:0] off,
                           input logic [CountW-1:0] cnt, input logic [MsW-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.file_id     <= fid;
    req_ch.byte_offset <= off;
    req_ch.byte_count  <= cnt;
    req_ch.now_ms      <= now;
    do @(posedge clk); while (!req_ch.ready);
    cur_file = fid;
    cur_next = {1'b0, off} + NextW'(cnt);
    clock_ms = now;
  endtask

  // holds off the sender until every response has been taken
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_settings(input logic en, input logic sw, input logic [SeekW-1:0] seek,
                               input logic [RateW-1:0] rate, input logic [AheadW-1:0] ahead);
    wait_drained();
    write_reg(CFG_MODEL_ENABLE, CfgDataW'(en));
    write_reg(CFG_TIMING_SWITCH, CfgDataW'(sw));
    write_reg(CFG_SEEK_COST, CfgDataW'(seek));
    write_reg(CFG_BYTES_PER_MS, CfgDataW'(rate));
    write_reg(CFG_MAX_AHEAD, CfgDataW'(ahead));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random_read();
    logic [63:0]        wide;
    logic [FileW-1:0]   fid;
    logic [OffsetW-1:0] off;
    logic [CountW-1:0]  cnt;
    logic [MsW-1:0]     now;
    int                 pick;
    pick = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (pick < 60) begin
      fid = cur_file;
      off = cur_next[OffsetW-1:0];
    end else if (pick < 82) begin
      fid = $urandom_range(0, 6);
      off = OffsetW'($urandom_range(0, 1 << 20));
    end else begin
      fid = $urandom;
      off = wide[OffsetW-1:0];
    end
    cnt  = ($urandom_range(99) < 85) ? $urandom_range(0, 300000) : $urandom;
    pick = $urandom_range(99);
    if (pick < 70) begin
      now = clock_ms + MsW'($urandom_range(0, 12));    // slow clock lets a backlog build
    end else if (pick < 85) begin
      now = clock_ms;
    end else begin
      wide = {$urandom, $urandom};
      now  = wide[MsW-1:0];
    end
    send_read(fid, off, cnt, now);
  endtask

  initial begin
    logic [SeekW-1:0]  seek;
    logic [RateW-1:0]  rate;
    logic [AheadW-1:0] ahead;
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.file_id      <= '0;
    req_ch.byte_offset  <= '0;
    req_ch.byte_count   <= '0;
    req_ch.now_ms       <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_MODEL_ENABLE;
    cfg_ch.data         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // model disabled out of reset: zero result, state untouched
    send_read('0, '0, 32'd100, 48'd10);
    send_read('1, '1, '1, '1);
    load_settings(1'b1, 1'b1, SeekCostRst, BytesPerMsRst, MaxAheadRst);
    // first read after reset at file 0 offset 0 continues, no seek
    send_read('0, '0, 32'd35000, 48'd0);
    send_read('0, 40'd35000, 32'd70000, 48'd0);
    send_read(32'd5, '0, '0, 48'd1);
    // huge reads push free time past now plus the backlog limit
    send_read(32'd5, '0, '1, 48'd2);
    send_read(32'd5, 40'h0_FFFF_FFFF, '1, 48'd3);
    // max seek, zero rate taken as one, no backlog allowed
    load_settings(1'b1, 1'b1, '1, '0, '0);
    send_read('1, '0, '1, 48'd100);
    send_read('1, 40'h0_FFFF_FFFF, 32'd1, 48'd101);
    // largest backlog, free time saturates near the top of the time range
    load_settings(1'b1, 1'b1, '0, 20'd1, '1);
    send_read(32'd9, '0, '1, '1);
    send_read(32'd9, 40'h0_FFFF_FFFF, '1, 48'hFFFF_FFFF_FFF0);
    // offset end past 40 bits cannot be continued
    send_read(32'd7, '1, '1, 48'd500);
    send_read(32'd7, '0, 32'd1, 48'd501);
    // timing switch off: zero result, then the stream continues without a seek
    load_settings(1'b1, 1'b0, SeekCostRst, '1, MaxAheadRst);
    send_read(32'd3, 40'd12345, '1, 48'd600);
    load_settings(1'b1, 1'b1, SeekCostRst, '1, MaxAheadRst);
    send_read(32'd7, 40'd1, 32'd1048575, 48'd602);
    send_read(32'd7, 40'd1048576, 32'd2097150, 48'd602);

    for (int blk = 0; blk < 10; blk++) begin
      seek  = (blk == 2) ? '0 : (blk == 3) ? '1 : SeekW'($urandom_range(0, 24'hFFFFFF));
      rate  = (blk == 4) ? 20'd1 : (blk == 5) ? '1 : (blk == 9) ? '0
            : RateW'($urandom_range(1000, 100000));
      ahead = (blk == 1) ? '0 : (blk == 3) ? '1 : AheadW'($urandom_range(0, 8000));
      load_settings(blk != 6, blk != 8, seek, rate, ahead);
      case (blk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int n = 0; n < 145; n++) begin
        if (n % 50 == 49) wait_drained();
        send_random_read();
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
